// ----- sv/rank_filter_3x3_rgb_core_defines.svh -----
// ---------------------------------------------------------------------------
// Rank filter assertion macros
// Shared concurrent assertion forms used by the rank filter RTL.
// ---------------------------------------------------------------------------
`ifndef RANK_FILTER_3X3_RGB_CORE_DEFINES_SVH
`define RANK_FILTER_3X3_RGB_CORE_DEFINES_SVH

// Antecedent in one cycle implies the consequent in the same cycle.
`define RF3_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define RF3_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rf3_pkg.sv -----
// ---------------------------------------------------------------------------
// Rank filter package
// Widths, mode codes, lane types and small rank helpers shared by the
// rank filter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rf3_pkg;

  // Window and pixel geometry.
  localparam int WIN_SIZE     = 9;
  localparam int WIN_ROWS     = 3;
  localparam int WIN_COLS     = 3;
  localparam int CHAN_W       = 8;
  localparam int PIX_W        = 24;
  localparam int OUT_CHANNELS = 3;
  localparam int CHANNELS_DEF = 3;

  // Rank mode register codes; the unused code behaves as the median.
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MED = 2'd2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [WIN_SIZE-1:0] win_t;

  // Partial ranks that one lane hands to the merge stage.
  typedef struct packed {
    chan_t mn;
    chan_t mx;
    chan_t lo;
    chan_t mid;
    chan_t hi;
  } rf3_lane_t;

  // Pipeline advance controls.
  typedef struct packed {
    logic adv_a;
    logic adv_b;
    logic adv_out;
  } rf3_ctrl_t;

  function automatic chan_t min2(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(chan_t a, chan_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic chan_t min3(chan_t a, chan_t b, chan_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic chan_t max3(chan_t a, chan_t b, chan_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

`default_nettype wire

// ----- sv/rf3_lane.sv -----
// ---------------------------------------------------------------------------
// Rank filter lane
// Ranks one 8-bit channel over a 3x3 window in two registered steps: the
// rows are sorted first, then the row results are reduced to the minimum,
// the maximum and the three median candidates.
// ---------------------------------------------------------------------------
`default_nettype none

module rf3_lane
  import rf3_pkg::*;
(
  input  wire logic      clk,
  input  wire win_t      win,
  input  wire rf3_ctrl_t ctrl,
  output rf3_lane_t      res
);

  chan_t row_min [WIN_ROWS];
  chan_t row_med [WIN_ROWS];
  chan_t row_max [WIN_ROWS];

  // Stage A: sort each window row of three values.
  always_ff @(posedge clk) begin
    if (ctrl.adv_a) begin
      for (int r = 0; r < WIN_ROWS; r++) begin
        row_min[r] <= min3(win[r*WIN_COLS], win[r*WIN_COLS+1], win[r*WIN_COLS+2]);
        row_med[r] <= med3(win[r*WIN_COLS], win[r*WIN_COLS+1], win[r*WIN_COLS+2]);
        row_max[r] <= max3(win[r*WIN_COLS], win[r*WIN_COLS+1], win[r*WIN_COLS+2]);
      end
    end
  end

  // Stage B: extremes of the window and the three median candidates.
  always_ff @(posedge clk) begin
    if (ctrl.adv_b) begin
      res.mn  <= min3(row_min[0], row_min[1], row_min[2]);
      res.mx  <= max3(row_max[0], row_max[1], row_max[2]);
      res.lo  <= max3(row_min[0], row_min[1], row_min[2]);
      res.mid <= med3(row_med[0], row_med[1], row_med[2]);
      res.hi  <= min3(row_max[0], row_max[1], row_max[2]);
    end
  end

endmodule

`default_nettype wire

// ----- sv/rf3_merge.sv -----
// ---------------------------------------------------------------------------
// Rank filter merge stage
// Finishes the median of each lane, picks the rank that the mode selects
// and holds the result pixel in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rf3_merge
  import rf3_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int LANES    = (CHANNELS < OUT_CHANNELS) ? CHANNELS : OUT_CHANNELS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rf3_ctrl_t         ctrl,
  input  wire logic              b_valid,
  input  wire logic [MODE_W-1:0] mode,
  input  wire rf3_lane_t         lane_res [LANES],
  output chan_t                  res [OUT_CHANNELS],
  output logic                   res_valid
);

  // Output valid follows the last lane stage whenever the register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.adv_out) begin
      res_valid <= b_valid;
    end
  end

  for (genvar c = 0; c < OUT_CHANNELS; c++) begin : g_chan
    if (c < LANES) begin : g_used
      chan_t pick;

      // Select the requested rank of this channel.
      always_comb begin
        case (mode)
          MODE_MIN: pick = lane_res[c].mn;
          MODE_MAX: pick = lane_res[c].mx;
          MODE_MED: pick = med3(lane_res[c].lo, lane_res[c].mid, lane_res[c].hi);
          default:  pick = med3(lane_res[c].lo, lane_res[c].mid, lane_res[c].hi);
        endcase
      end

      always_ff @(posedge clk) begin
        if (ctrl.adv_out) begin
          res[c] <= pick;
        end
      end
    end else begin : g_unused
      // Channels without a lane read as zero.
      assign res[c] = '0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rank_filter_3x3_rgb_core.sv -----
// 3x3 RGB rank filter core.
// Input channel: one 3x3 window of packed RGB pixels per transfer on
// in_valid / in_stall; nine 24-bit fields, channel 0 in bits 7:0.
// Output channel: one pixel per window on out_valid / out_stall, each 8-bit
// channel ranked on its own over the nine window values.
// Configuration: rank_mode is written on cfg_valid / cfg_ready (always
// ready); 0 minimum, 1 maximum, 2 or 3 median. Write it only while idle.
// A window passes through three register stages in order: row sort, row
// reduction, rank select. One window is taken per clock while the output
// is not stalled.
// When the receiver stalls, the output pixel holds and the stages behind it
// keep filling until every stage is occupied; only then is in_stall raised.
// Reset (rst, synchronous) empties the pipeline and sets rank_mode to the
// median.
// Channels beyond CHANNELS (when below 3) output zero.
// ---------------------------------------------------------------------------
// Rank filter top level
// Lanes per color channel, pipeline control and the merge stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rank_filter_3x3_rgb_core_defines.svh"

module rank_filter_3x3_rgb_core
  import rf3_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [MODE_W-1:0] rank_mode,
  // Input window
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PIX_W-1:0]  pix_top_left,
  input  wire logic [PIX_W-1:0]  pix_top_mid,
  input  wire logic [PIX_W-1:0]  pix_top_right,
  input  wire logic [PIX_W-1:0]  pix_mid_left,
  input  wire logic [PIX_W-1:0]  pix_center,
  input  wire logic [PIX_W-1:0]  pix_mid_right,
  input  wire logic [PIX_W-1:0]  pix_bot_left,
  input  wire logic [PIX_W-1:0]  pix_bot_mid,
  input  wire logic [PIX_W-1:0]  pix_bot_right,
  // Output pixel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAN_W-1:0]      out_chan0,
  output logic [CHAN_W-1:0]      out_chan1,
  output logic [CHAN_W-1:0]      out_chan2
);

  localparam int LANES = (CHANNELS < OUT_CHANNELS) ? CHANNELS : OUT_CHANNELS;

  logic [MODE_W-1:0] mode;
  logic              vld_a;
  logic              vld_b;
  rf3_ctrl_t         ctrl;
  logic [PIX_W-1:0]  pix [WIN_SIZE];
  rf3_lane_t         lane_res [LANES];
  chan_t             res [OUT_CHANNELS];

  // Mode register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MED;
    end else if (cfg_valid) begin
      mode <= rank_mode;
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    ctrl.adv_out = !out_valid || !out_stall;
    ctrl.adv_b   = !vld_b || ctrl.adv_out;
    ctrl.adv_a   = !vld_a || ctrl.adv_b;
  end

  assign in_stall = !ctrl.adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (ctrl.adv_a) begin
        vld_a <= in_valid;
      end
      if (ctrl.adv_b) begin
        vld_b <= vld_a;
      end
    end
  end

  // Window in raster order.
  assign pix[0] = pix_top_left;
  assign pix[1] = pix_top_mid;
  assign pix[2] = pix_top_right;
  assign pix[3] = pix_mid_left;
  assign pix[4] = pix_center;
  assign pix[5] = pix_mid_right;
  assign pix[6] = pix_bot_left;
  assign pix[7] = pix_bot_mid;
  assign pix[8] = pix_bot_right;

  // One ranking lane per filtered channel.
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    win_t win;

    for (genvar k = 0; k < WIN_SIZE; k++) begin : g_tap
      assign win[k] = pix[k][c*CHAN_W +: CHAN_W];
    end

    rf3_lane u_lane (
      .clk  (clk),
      .win  (win),
      .ctrl (ctrl),
      .res  (lane_res[c])
    );
  end

  // Rank select and output register.
  rf3_merge #(
    .CHANNELS (CHANNELS),
    .LANES    (LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .b_valid   (vld_b),
    .mode      (mode),
    .lane_res  (lane_res),
    .res       (res),
    .res_valid (out_valid)
  );

  assign out_chan0 = res[0];
  assign out_chan1 = res[1];
  assign out_chan2 = res[2];

  // The input is only held off while every stage is occupied.
  `RF3_ASSERT_SAME(a_stall_needs_full, in_stall, vld_a && vld_b && out_valid, "stall with free stage")
  // An accepted window always occupies the first stage next.
  `RF3_ASSERT_NEXT(a_accept_fills_a, in_valid && !in_stall, vld_a, "accepted window lost")
  // A finished result moves into a free output register.
  `RF3_ASSERT_NEXT(a_b_to_out, vld_b && !out_valid, out_valid, "result not forwarded")

endmodule

`default_nettype wire
